// ===== rtl/amc_pkg.sv =====
// ----------------------------------------------------------------------------
// amc_pkg
// Shared widths, codes and controller/datapath interface types for the
// address map cache.
// ----------------------------------------------------------------------------
package amc_pkg;

  localparam int AddrW  = 63;
  localparam int StampW = 32;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_INSERT = 1'b1
  } kind_e;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic read;
    logic scan_start;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic index_done;
    logic need_scan;
    logic scan_last;
  } status_t;

endpackage

// ===== rtl/amc_req_if.sv =====
// ----------------------------------------------------------------------------
// amc_req_if
// Request channel: lookup or insert transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface amc_req_if import amc_pkg::*;;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [AddrW-1:0] key;
  logic [AddrW-1:0] phys_addr;
  logic [AddrW-1:0] stru_addr;

  modport source (
    output valid, kind, key, phys_addr, stru_addr,
    input  ready
  );

  modport sink (
    input  valid, kind, key, phys_addr, stru_addr,
    output ready
  );

endinterface

// ===== rtl/amc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// amc_rsp_if
// Response channel: hit flag and mapped address with valid/ready handshake.
// ----------------------------------------------------------------------------
interface amc_rsp_if import amc_pkg::*;;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [AddrW-1:0] mapped_address;

  modport source (
    output valid, hit, mapped_address,
    input  ready
  );

  modport sink (
    input  valid, hit, mapped_address,
    output ready
  );

endinterface

// ===== rtl/amc_set_index.sv =====
// ----------------------------------------------------------------------------
// amc_set_index
// Set index unit: computes (key / WAYS) mod SETS. Power-of-two geometry is a
// bit slice; otherwise the key residue modulo WAYS*SETS is summed four key
// bits per cycle and then divided by WAYS with a reciprocal multiply.
// ----------------------------------------------------------------------------
module amc_set_index import amc_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 128,
  parameter int SetW = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AddrW-1:0] key_i,
  output logic             done_o,
  output logic [SetW-1:0]  set_o
);

  localparam bit Pow2 = ((WAYS & (WAYS - 1)) == 0) && ((SETS & (SETS - 1)) == 0);

  logic            done_q;
  logic [SetW-1:0] set_q;

  assign done_o = done_q;
  assign set_o  = set_q;

  if (Pow2) begin : g_slice
    localparam int WayLog = $clog2(WAYS);

    logic [SetW-1:0] set_d;

    assign set_d = SetW'((key_i >> WayLog) & AddrW'(SETS - 1));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        set_q <= set_d;
      end
    end
  end else begin : g_serial
    localparam int Modulus = WAYS * SETS;
    localparam int Digit   = 4;
    localparam int DigW    = $clog2(Digit);
    localparam int Rounds  = (AddrW + Digit - 1) / Digit;
    localparam int CntW    = $clog2(Rounds);
    localparam int ShW     = Rounds * Digit;
    localparam int ResW    = $clog2(Modulus);
    localparam int AccW    = ResW + DigW + 1;
    localparam int RecipSh = ResW + 5;
    localparam int ProdW   = 2 * ResW + 6;
    localparam longint unsigned Recip = ((64'd1 << RecipSh) + WAYS - 1) / WAYS;

    typedef logic [ShW-1:0][ResW-1:0] weight_t;

    // 2^i mod (WAYS * SETS) for every key bit
    function automatic weight_t weights();
      weight_t         tbl;
      longint unsigned p;
      tbl = '0;
      p   = 1;
      for (int i = 0; i < ShW; i++) begin
        tbl[i] = ResW'(p);
        p      = p * 2;
        if (p >= Modulus) begin
          p = p - Modulus;
        end
      end
      return tbl;
    endfunction

    localparam weight_t Weight = weights();

    logic             busy_q;
    logic             div_q;
    logic [CntW-1:0]  cnt_q;
    logic [ShW-1:0]   sh_q;
    logic [ResW-1:0]  acc_q, acc_d;
    logic [ProdW-1:0] prod;

    always_comb begin
      logic [AccW-1:0] sum;
      sum = AccW'(acc_q);
      for (int j = 0; j < Digit; j++) begin
        if (sh_q[j]) begin
          sum = sum + AccW'(Weight[{cnt_q, DigW'(j)}]);
        end
      end
      for (int k = DigW; k >= 0; k--) begin
        if (sum >= AccW'(Modulus << k)) begin
          sum = sum - AccW'(Modulus << k);
        end
      end
      acc_d = ResW'(sum);
    end

    assign prod = ProdW'(acc_q) * ProdW'(Recip);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        div_q  <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        div_q  <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Rounds - 1)) begin
          busy_q <= 1'b0;
          div_q  <= 1'b1;
        end
      end else if (div_q) begin
        div_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= ShW'(key_i);
        acc_q <= '0;
      end else if (busy_q) begin
        sh_q  <= sh_q >> Digit;
        acc_q <= acc_d;
      end else if (div_q) begin
        set_q <= SetW'(prod >> RecipSh);
      end
    end
  end

endmodule

// ===== rtl/amc_datapath.sv =====
// ----------------------------------------------------------------------------
// amc_datapath
// Set memories, way compare, victim scan, stamp counter and result register.
// ----------------------------------------------------------------------------
module amc_datapath import amc_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             kind_i,
  input  logic [AddrW-1:0] key_i,
  input  logic [AddrW-1:0] phys_i,
  input  logic [AddrW-1:0] stru_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  output logic             hit_o,
  output logic [AddrW-1:0] mapped_o
);

  localparam int SetW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WayW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef logic [WAYS-1:0][AddrW-1:0]  addr_row_t;
  typedef logic [WAYS-1:0][StampW-1:0] stamp_row_t;

  logic [WAYS-1:0] valid_mem [SETS];
  addr_row_t       phys_mem  [SETS];
  addr_row_t       stru_mem  [SETS];
  stamp_row_t      stamp_mem [SETS];

  kind_e             kind_q;
  logic [AddrW-1:0]  key_q, phys_q, stru_q;
  logic              match_q;
  logic [StampW-1:0] stamp_cnt_q;
  logic [SetW-1:0]   clr_q;
  logic [WayW-1:0]   victim_q, scan_q;
  logic [WAYS-1:0]   rd_valid_q;
  addr_row_t         rd_phys_q, rd_stru_q;
  stamp_row_t        rd_stamp_q;
  logic              hit_q;
  logic [AddrW-1:0]  mapped_q;

  logic              index_done;
  logic [SetW-1:0]   set_idx;
  logic [SetW-1:0]   addr;
  logic [WAYS-1:0]   match_vec;
  logic              any_hit, full;
  logic [WayW-1:0]   hit_way, free_way, wr_way;
  logic [WAYS-1:0]   wr_valid;
  addr_row_t         wr_phys, wr_stru;
  stamp_row_t        wr_stamp;
  logic              we_entry, we_stamp;
  logic [AddrW-1:0]  hit_other;

  amc_set_index #(
    .WAYS (WAYS),
    .SETS (SETS),
    .SetW (SetW)
  ) u_set_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .key_i   (key_i),
    .done_o  (index_done),
    .set_o   (set_idx)
  );

  assign addr = cmd_i.clear_step ? clr_q : set_idx;

  always_comb begin
    match_vec = '0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      match_vec[w] = rd_valid_q[w] &&
                     ((match_q ? rd_stru_q[w] : rd_phys_q[w]) == key_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match_vec[w]) begin
        hit_way = WayW'(w);
      end
      if (!rd_valid_q[w]) begin
        free_way = WayW'(w);
      end
    end
  end

  assign any_hit   = |match_vec;
  assign full      = &rd_valid_q;
  assign hit_other = match_q ? rd_phys_q[hit_way] : rd_stru_q[hit_way];

  always_comb begin
    if (kind_q == KIND_LOOKUP) begin
      wr_way = hit_way;
    end else if (full) begin
      wr_way = victim_q;
    end else begin
      wr_way = free_way;
    end
    wr_valid         = rd_valid_q;
    wr_phys          = rd_phys_q;
    wr_stru          = rd_stru_q;
    wr_stamp         = rd_stamp_q;
    wr_valid[wr_way] = 1'b1;
    wr_phys[wr_way]  = phys_q;
    wr_stru[wr_way]  = stru_q;
    wr_stamp[wr_way] = stamp_cnt_q;
  end

  assign we_entry = cmd_i.commit && (kind_q == KIND_INSERT);
  assign we_stamp = cmd_i.commit && ((kind_q == KIND_INSERT) || any_hit);

  assign status_o.clear_last = (clr_q == SetW'(SETS - 1));
  assign status_o.index_done = index_done;
  assign status_o.need_scan  = (WAYS > 1) && (kind_q == KIND_INSERT) && full;
  assign status_o.scan_last  = (scan_q == WayW'(WAYS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      valid_mem[addr] <= '0;
    end else if (we_entry) begin
      valid_mem[addr] <= wr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_entry) begin
      phys_mem[addr] <= wr_phys;
      stru_mem[addr] <= wr_stru;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_stamp) begin
      stamp_mem[addr] <= wr_stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_valid_q <= valid_mem[addr];
      rd_phys_q  <= phys_mem[addr];
      rd_stru_q  <= stru_mem[addr];
      rd_stamp_q <= stamp_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q     <= 1'b0;
      stamp_cnt_q <= '0;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        match_q <= cfg_wdata_i;
      end
      if (we_stamp) begin
        stamp_cnt_q <= stamp_cnt_q + 1'b1;
      end
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q   <= kind_e'(kind_i);
      key_q    <= key_i;
      phys_q   <= phys_i;
      stru_q   <= stru_i;
      victim_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (rd_stamp_q[scan_q] < rd_stamp_q[victim_q]) begin
        victim_q <= scan_q;
      end
    end
    if (cmd_i.scan_start) begin
      scan_q <= WayW'(1);
    end else if (cmd_i.scan_step) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.commit) begin
      hit_q    <= (kind_q == KIND_LOOKUP) && any_hit;
      mapped_q <= ((kind_q == KIND_LOOKUP) && any_hit) ? hit_other : '0;
    end
  end

  assign hit_o    = hit_q;
  assign mapped_o = mapped_q;

endmodule

// ===== rtl/amc_ctrl.sv =====
// ----------------------------------------------------------------------------
// amc_ctrl
// Controller: clearing pass, transaction sequencing and result valid flag.
// ----------------------------------------------------------------------------
module amc_ctrl import amc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_CMP,
    ST_SCAN,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (status_i.index_done) begin
          cmd_o.read = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status_i.need_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/address_map_cache_lru.sv =====
// ----------------------------------------------------------------------------
// address_map_cache_lru
// Set-associative physical/structural address map with timestamp LRU.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries lookup (kind 0) or insert (kind 1) transactions; rsp_chan
//   returns one transaction per request: hit and the mapped address (zero on
//   a miss or an insert). cfg_we_i/cfg_wdata_i write the match mode (0 matches
//   physical addresses, 1 structural addresses); the user must write it only
//   while the block is idle, which the block itself does not enforce.
//   Sequencing: with power-of-two WAYS and SETS a request passes through
//   accept, set read, and compare and write-back. Other geometries add 16
//   residue rounds and one divide step in the set-index unit. An insert into
//   a full set adds a victim scan over the stamps. One request is in flight
//   at a time; the result sits in an output register, so the next request is
//   accepted while it waits. If the receiver stalls, a finished request holds
//   at its write-back until the output register frees up.
//   Reset: the valid bits are swept one set per cycle, over all SETS sets,
//   with req_chan.ready low; the stamp counter and the mode register clear.
// ----------------------------------------------------------------------------
module address_map_cache_lru import amc_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amc_req_if.sink   req_chan,
  amc_rsp_if.source rsp_chan,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  amc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_chan.valid),
    .in_ready_o  (req_chan.ready),
    .out_valid_o (rsp_chan.valid),
    .out_ready_i (rsp_chan.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  amc_datapath #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (req_chan.kind),
    .key_i       (req_chan.key),
    .phys_i      (req_chan.phys_addr),
    .stru_i      (req_chan.stru_addr),
    .cmd_i       (cmd),
    .status_o    (status),
    .hit_o       (rsp_chan.hit),
    .mapped_o    (rsp_chan.mapped_address)
  );

endmodule
